// File: design/sctg_pkg.sv
// Shared types and constants for the spatial capture trigger gate.
`default_nettype none

package sctg_pkg;

    localparam int HIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(HIST_DEPTH + 2);
    localparam int DIST_LAT   = 3;
    localparam int POS_W      = 24;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 16;
    localparam int MSQ_W      = 2 * STEP_W;
    localparam int SQ_W       = 2 * (POS_W + 1);

    localparam logic REG_MIN_STEP = 1'b0;
    localparam logic REG_COOLDOWN = 1'b1;

    typedef logic signed [POS_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } pos_t;

    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_COOLDOWN = 2'd1,
        VERDICT_STEP     = 2'd2,
        VERDICT_NEAR     = 2'd3
    } verdict_t;

    typedef struct packed {
        logic valid;
        logic is_hist;
        pos_t a;
        pos_t b;
    } dist_req_t;

    typedef struct packed {
        logic valid;
        logic is_hist;
        logic near;
    } dist_res_t;

endpackage

`default_nettype wire

// File: design/sctg_cell.sv
// One history cell: holds a trigger point and passes it to the next cell on shift.
`default_nettype none

module sctg_cell (
    input  wire                   aclk,
    input  wire                   shift_en,
    input  wire sctg_pkg::pos_t   d,
    output sctg_pkg::pos_t        q
);

    sctg_pkg::pos_t pos_reg;
    sctg_pkg::pos_t pos_next;

    always_comb begin
        pos_next = shift_en ? d : pos_reg;
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
    end

    assign q = pos_reg;

endmodule

`default_nettype wire

// File: design/sctg_dist.sv
// Pipelined squared-distance compare against the squared minimum step.
`default_nettype none

module sctg_dist (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire sctg_pkg::dist_req_t     req,
    input  wire [sctg_pkg::MSQ_W-1:0]    min_sq,
    output sctg_pkg::dist_res_t          res
);

    localparam int DW = sctg_pkg::POS_W + 1;
    localparam int SW = sctg_pkg::SQ_W;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        ax;
    logic [DW-1:0]        ay;

    logic          s1_valid_reg, s1_valid_next;
    logic          s1_hist_reg,  s1_hist_next;
    logic [DW-1:0] ax_reg,       ax_next;
    logic [DW-1:0] ay_reg,       ay_next;

    logic          s2_valid_reg, s2_valid_next;
    logic          s2_hist_reg,  s2_hist_next;
    logic [SW-1:0] sqx_reg,      sqx_next;
    logic [SW-1:0] sqy_reg,      sqy_next;

    logic          s3_valid_reg, s3_valid_next;
    logic          s3_hist_reg,  s3_hist_next;
    logic          near_reg,     near_next;

    logic [SW:0]   sum;

    always_comb begin
        dx = {req.a.x[sctg_pkg::POS_W-1], req.a.x} - {req.b.x[sctg_pkg::POS_W-1], req.b.x};
        dy = {req.a.y[sctg_pkg::POS_W-1], req.a.y} - {req.b.y[sctg_pkg::POS_W-1], req.b.y};
        ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

        s1_valid_next = req.valid;
        s1_hist_next  = req.is_hist;
        ax_next       = ax;
        ay_next       = ay;

        s2_valid_next = s1_valid_reg;
        s2_hist_next  = s1_hist_reg;
        sqx_next      = SW'(ax_reg) * SW'(ax_reg);
        sqy_next      = SW'(ay_reg) * SW'(ay_reg);

        sum           = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        s3_valid_next = s2_valid_reg;
        s3_hist_next  = s2_hist_reg;
        // history test uses half the step: compare four times the square
        if (s2_hist_reg) begin
            near_next = {sum, 2'b00} < (SW + 3)'(min_sq);
        end else begin
            near_next = sum < (SW + 1)'(min_sq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
        s1_hist_reg <= s1_hist_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        s2_hist_reg <= s2_hist_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        s3_hist_reg <= s3_hist_next;
        near_reg    <= near_next;
    end

    assign res.valid   = s3_valid_reg;
    assign res.is_hist = s3_hist_reg;
    assign res.near    = near_reg;

endmodule

`default_nettype wire

// File: design/spatial_capture_trigger_gate_core.sv
// Top level: trigger gate with a rotating chain of history cells and one distance unit.
// A position update is accepted while idle and produces no result.
// A request passes ST_ISSUE (a check against the last point, then one per history cell
// as the chain rotates), ST_DRAIN for the three distance stages, and ST_DONE, which raises
// m_tvalid once the output register is free; the next item is taken back in ST_IDLE.
// Synchronous active-low reset restores the step and cooldown registers to 500 and 1000 and
// clears last point, time, robot position and history count; cell contents are not cleared.
`default_nettype none

module spatial_capture_trigger_gate_core (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [79:0] s_tdata,   // x_pos[23:0], y_pos[47:24], time_ms[79:48]
    input  wire         s_tuser,   // op

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // fire[0], verdict[2:1], used_actual[3], zero[7:4]

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = sctg_pkg::HIST_DEPTH;
    localparam int CW = sctg_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                         state_reg,     state_next;
    logic [CW-1:0]                  idx_reg,       idx_next;
    logic [CW-1:0]                  count_reg,     count_next;
    logic [sctg_pkg::STEP_W-1:0]    min_step_reg,  min_step_next;
    logic [sctg_pkg::STEP_W-1:0]    cooldown_reg,  cooldown_next;
    logic [sctg_pkg::MSQ_W-1:0]     min_sq_reg,    min_sq_next;
    sctg_pkg::pos_t                 robot_reg,     robot_next;
    logic                           robot_ok_reg,  robot_ok_next;
    sctg_pkg::pos_t                 last_reg,      last_next;
    logic [sctg_pkg::TIME_W-1:0]    last_time_reg, last_time_next;
    sctg_pkg::pos_t                 pt_reg,        pt_next;
    logic [sctg_pkg::TIME_W-1:0]    now_reg,       now_next;
    logic                           used_reg,      used_next;
    logic                           cool_reg,      cool_next;
    logic                           step_fail_reg, step_fail_next;
    logic                           hist_fail_reg, hist_fail_next;
    logic                           m_valid_reg,   m_valid_next;
    logic [7:0]                     m_data_reg,    m_data_next;

    sctg_pkg::pos_t      in_pos;
    sctg_pkg::pos_t      sel_pos;
    logic [sctg_pkg::TIME_W-1:0] in_time;
    logic [sctg_pkg::TIME_W-1:0] elapsed;
    logic                s_xfer;
    logic                cfg_wr;
    logic                rotate;
    logic                insert;
    logic                shift_en;
    sctg_pkg::pos_t      cell_q [N];
    sctg_pkg::pos_t      tail;
    sctg_pkg::dist_req_t req;
    sctg_pkg::dist_res_t res;
    sctg_pkg::verdict_t  verdict;

    assign in_pos.x = s_tdata[23:0];
    assign in_pos.y = s_tdata[47:24];
    assign in_time  = s_tdata[79:48];
    assign tail     = cell_q[N-1];
    assign shift_en = rotate | insert;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid & s_tready;
    assign cfg_wr   = psel & penable & pwrite;
    assign pready   = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        case (paddr[2])
            sctg_pkg::REG_MIN_STEP: prdata = 32'(min_step_reg);
            sctg_pkg::REG_COOLDOWN: prdata = 32'(cooldown_reg);
            default:                prdata = '0;
        endcase
    end

    generate
        for (genvar i = 0; i < N; i++) begin : g_cell
            sctg_pkg::pos_t d;
            if (i == 0) begin : g_head
                assign d = insert ? pt_reg : tail;
            end else begin : g_link
                assign d = cell_q[i-1];
            end
            sctg_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d        (d),
                .q        (cell_q[i])
            );
        end
    endgenerate

    sctg_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .min_sq  (min_sq_reg),
        .res     (res)
    );

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        min_step_next  = min_step_reg;
        cooldown_next  = cooldown_reg;
        min_sq_next    = min_sq_reg;
        robot_next     = robot_reg;
        robot_ok_next  = robot_ok_reg;
        last_next      = last_reg;
        last_time_next = last_time_reg;
        pt_next        = pt_reg;
        now_next       = now_reg;
        used_next      = used_reg;
        cool_next      = cool_reg;
        step_fail_next = step_fail_reg;
        hist_fail_next = hist_fail_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        rotate         = 1'b0;
        insert         = 1'b0;
        verdict        = sctg_pkg::VERDICT_OK;
        sel_pos        = robot_ok_reg ? robot_reg : in_pos;
        elapsed        = in_time - last_time_reg;

        req.valid   = 1'b0;
        req.is_hist = 1'b0;
        req.a       = pt_reg;
        req.b       = last_reg;

        if (cfg_wr) begin
            case (paddr[2])
                sctg_pkg::REG_MIN_STEP: min_step_next = pwdata[sctg_pkg::STEP_W-1:0];
                sctg_pkg::REG_COOLDOWN: cooldown_next = pwdata[sctg_pkg::STEP_W-1:0];
                default: ;
            endcase
        end

        // drop the result once the downstream side takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // fold distance results into the failure flags
        if (res.valid && res.near) begin
            if (res.is_hist) begin
                hist_fail_next = 1'b1;
            end else begin
                step_fail_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (sctg_pkg::op_t'(s_tuser) == sctg_pkg::OP_UPDATE) begin
                        robot_next    = in_pos;
                        robot_ok_next = 1'b1;
                    end else begin
                        pt_next        = sel_pos;
                        now_next       = in_time;
                        used_next      = robot_ok_reg;
                        cool_next      = elapsed < sctg_pkg::TIME_W'(cooldown_reg);
                        min_sq_next    = sctg_pkg::MSQ_W'(min_step_reg) *
                                         sctg_pkg::MSQ_W'(min_step_reg);
                        step_fail_next = 1'b0;
                        hist_fail_next = 1'b0;
                        idx_next       = '0;
                        state_next     = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                if (idx_reg == '0) begin
                    req.valid = 1'b1;
                end else begin
                    // tail holds cell N-idx; only written cells take part
                    req.valid   = (CW'(N) - idx_reg) < count_reg;
                    req.is_hist = 1'b1;
                    req.b       = tail;
                    rotate      = 1'b1;
                end
                if (idx_reg == CW'(N)) begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (idx_reg == CW'(sctg_pkg::DIST_LAT - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (cool_reg) begin
                    verdict = sctg_pkg::VERDICT_COOLDOWN;
                end else if (step_fail_reg) begin
                    verdict = sctg_pkg::VERDICT_STEP;
                end else if (hist_fail_reg) begin
                    verdict = sctg_pkg::VERDICT_NEAR;
                end else begin
                    verdict = sctg_pkg::VERDICT_OK;
                end
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, used_reg, verdict,
                                    verdict == sctg_pkg::VERDICT_OK};
                    if (verdict == sctg_pkg::VERDICT_OK) begin
                        insert         = 1'b1;
                        last_next      = pt_reg;
                        last_time_next = now_reg;
                        if (count_reg != CW'(N)) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            min_step_reg  <= 16'd500;
            cooldown_reg  <= 16'd1000;
            robot_reg     <= '0;
            robot_ok_reg  <= 1'b0;
            last_reg      <= '0;
            last_time_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            min_step_reg  <= min_step_next;
            cooldown_reg  <= cooldown_next;
            robot_reg     <= robot_next;
            robot_ok_reg  <= robot_ok_next;
            last_reg      <= last_next;
            last_time_reg <= last_time_next;
            m_valid_reg   <= m_valid_next;
        end
        min_sq_reg    <= min_sq_next;
        pt_reg        <= pt_next;
        now_reg       <= now_next;
        used_reg      <= used_next;
        cool_reg      <= cool_next;
        step_fail_reg <= step_fail_next;
        hist_fail_reg <= hist_fail_next;
        m_data_reg    <= m_data_next;
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the spatial capture trigger gate: directed table, then random phases per setting.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = sctg_pkg::HIST_DEPTH + 12;
    localparam sctg_pkg::coord_t C_MIN = 24'sh800000;
    localparam sctg_pkg::coord_t C_MAX = 24'sh7FFFFF;

    typedef struct packed {
        logic               fire;
        sctg_pkg::verdict_t verdict;
        logic               used_actual;
    } gate_result_t;

    typedef struct packed {
        sctg_pkg::op_t      op;
        sctg_pkg::coord_t   x;
        sctg_pkg::coord_t   y;
        logic [31:0]        t;
        logic               typed;
        sctg_pkg::verdict_t verdict;
        logic               used;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // x_pos[23:0], y_pos[47:24], time_ms[79:48]
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // fire[0], verdict[2:1], used_actual[3], zero[7:4]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted block state
    logic [15:0]      min_step;
    logic [15:0]      cooldown;
    sctg_pkg::coord_t trig_last_x;
    sctg_pkg::coord_t trig_last_y;
    logic [31:0]      trig_last_time;
    sctg_pkg::coord_t hist_x [sctg_pkg::HIST_DEPTH];
    sctg_pkg::coord_t hist_y [sctg_pkg::HIST_DEPTH];
    int               hist_count;
    int               hist_head;
    sctg_pkg::coord_t robot_x;
    sctg_pkg::coord_t robot_y;
    bit               robot_valid;

    gate_result_t pending_verdicts[$];
    stim_row_t    directed_rows[$];
    logic [31:0]  clock_ms;
    bit           steady;
    int           mismatches;
    int           cycle_count;

    spatial_capture_trigger_gate_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic longint unsigned sq_dist(sctg_pkg::coord_t ax, sctg_pkg::coord_t ay,
                                                sctg_pkg::coord_t bx, sctg_pkg::coord_t by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    // Decide one request and advance the trigger state on acceptance.
    function automatic gate_result_t judge_request(sctg_pkg::coord_t px, sctg_pkg::coord_t py,
                                                   logic [31:0] now);
        gate_result_t      r;
        sctg_pkg::coord_t  x;
        sctg_pkg::coord_t  y;
        longint unsigned   ms64;
        longint unsigned   min_sq;
        logic [31:0]       elapsed;
        x = robot_valid ? robot_x : px;
        y = robot_valid ? robot_y : py;
        r.used_actual = robot_valid;
        ms64 = 64'(min_step);
        min_sq = ms64 * ms64;
        elapsed = now - trig_last_time;
        r.verdict = sctg_pkg::VERDICT_OK;
        if (elapsed < {16'd0, cooldown}) begin
            r.verdict = sctg_pkg::VERDICT_COOLDOWN;
        end else if (sq_dist(x, y, trig_last_x, trig_last_y) < min_sq) begin
            r.verdict = sctg_pkg::VERDICT_STEP;
        end else begin
            for (int i = 0; i < hist_count && r.verdict == sctg_pkg::VERDICT_OK; i++) begin
                if (4 * sq_dist(x, y, hist_x[i], hist_y[i]) < min_sq)
                    r.verdict = sctg_pkg::VERDICT_NEAR;
            end
        end
        if (r.verdict == sctg_pkg::VERDICT_OK) begin
            trig_last_x = x;
            trig_last_y = y;
            trig_last_time = now;
            hist_x[hist_head] = x;
            hist_y[hist_head] = y;
            hist_head = (hist_head + 1) % sctg_pkg::HIST_DEPTH;
            if (hist_count < sctg_pkg::HIST_DEPTH)
                hist_count++;
        end
        r.fire = (r.verdict == sctg_pkg::VERDICT_OK);
        return r;
    endfunction

    // Present one item, hold until the transfer, then note the robot position or log the expectation.
    task automatic send_item(sctg_pkg::op_t op, sctg_pkg::coord_t x, sctg_pkg::coord_t y,
                             logic [31:0] t, bit typed, sctg_pkg::verdict_t v, bit used);
        gate_result_t r;
        if (!steady) begin
            while ($urandom_range(99) < 26) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {t, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (op == sctg_pkg::OP_UPDATE) begin
            robot_x = x;
            robot_y = y;
            robot_valid = 1'b1;
        end else begin
            r = judge_request(x, y, t);
            if (typed) begin
                r.verdict = v;
                r.fire = (v == sctg_pkg::VERDICT_OK);
                r.used_actual = used;
            end
            pending_verdicts = {pending_verdicts, r};
        end
    endtask

    // Hold off the sender until every result is back and the block is quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == sctg_pkg::REG_MIN_STEP)
            min_step = value;
        else
            cooldown = value;
    endtask

    task automatic add_row(sctg_pkg::op_t op, sctg_pkg::coord_t x, sctg_pkg::coord_t y,
                           logic [31:0] t, bit typed, sctg_pkg::verdict_t v, bit used);
        stim_row_t row;
        row = '{op, x, y, t, typed, v, used};
        directed_rows = {directed_rows, row};
    endtask

    // Random walk around the last trigger point and the history ring.
    task automatic run_phase(int n_items);
        int               sent;
        int               span;
        int               off_x;
        int               off_y;
        int               h;
        sctg_pkg::coord_t bx;
        sctg_pkg::coord_t by;
        sent = 0;
        span = 2 * int'(min_step) + 2;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                case ($urandom_range(9))
                    0: begin
                        bx = 24'($urandom);
                        by = 24'($urandom);
                    end
                    1, 2, 3: begin
                        h = (hist_count > 0) ? $urandom_range(hist_count - 1) : 0;
                        off_x = $urandom_range(span / 2);
                        off_y = $urandom_range(span / 2);
                        bx = 24'(hist_x[h] + off_x - span / 4);
                        by = 24'(hist_y[h] + off_y - span / 4);
                    end
                    default: begin
                        off_x = $urandom_range(2 * span);
                        off_y = $urandom_range(2 * span);
                        bx = 24'(trig_last_x + off_x - span);
                        by = 24'(trig_last_y + off_y - span);
                    end
                endcase
                send_item(sctg_pkg::OP_UPDATE, bx, by, $urandom, 1'b0,
                          sctg_pkg::VERDICT_OK, 1'b0);
                sent++;
            end
            case ($urandom_range(9))
                0:       clock_ms = clock_ms + $urandom;
                1, 2:    clock_ms = trig_last_time + cooldown - 1 + $urandom_range(2);
                default: clock_ms = clock_ms + $urandom_range(2 * int'(cooldown) + 2);
            endcase
            send_item(sctg_pkg::OP_REQUEST, 24'($urandom), 24'($urandom), clock_ms, 1'b0,
                      sctg_pkg::VERDICT_OK, 1'b0);
            sent++;
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 26);
    end

    always @(posedge aclk) begin
        gate_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d: fire %0b verdict %0d used %0b",
                             cycle_count, m_tdata[0], m_tdata[2:1], m_tdata[3]);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.fire || m_tdata[2:1] !== want.verdict ||
                    m_tdata[3] !== want.used_actual) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch at cycle %0d: expected fire %0b verdict %0d ",
                                  "used %0b, got fire %0b verdict %0d used %0b"},
                                 cycle_count, want.fire, want.verdict, want.used_actual,
                                 m_tdata[0], m_tdata[2:1], m_tdata[3]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int          p;
        logic [15:0] ms;
        logic [15:0] cd;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        steady   = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        min_step = 16'd500;
        cooldown = 16'd1000;
        trig_last_x = '0;
        trig_last_y = '0;
        trig_last_time = '0;
        hist_count = 0;
        hist_head = 0;
        robot_x = '0;
        robot_y = '0;
        robot_valid = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Planned positions first; cooldown from time zero, step from the origin.
        add_row(sctg_pkg::OP_REQUEST, 24'sd0, 24'sd0, 32'd0, 1'b1,
                sctg_pkg::VERDICT_COOLDOWN, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd0, 24'sd0, 32'd999, 1'b1,
                sctg_pkg::VERDICT_COOLDOWN, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd0, 24'sd0, 32'd1000, 1'b1,
                sctg_pkg::VERDICT_STEP, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd499, 24'sd0, 32'd1000, 1'b1,
                sctg_pkg::VERDICT_STEP, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd500, 24'sd0, 32'd1000, 1'b1,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd1000, 24'sd0, 32'd2000, 1'b1,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd300, 24'sd0, 32'd3000, 1'b1,
                sctg_pkg::VERDICT_NEAR, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd1000, -24'sd499, 32'd3000, 1'b1,
                sctg_pkg::VERDICT_STEP, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, C_MIN, C_MIN, 32'd4000, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, C_MAX, C_MAX, 32'd5000, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, C_MAX, C_MIN, 32'hFFFF_FFFF, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        // Elapsed time across the wrap
        add_row(sctg_pkg::OP_REQUEST, 24'sd0, 24'sd0, 32'h0000_01F0, 1'b1,
                sctg_pkg::VERDICT_COOLDOWN, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd0, 24'sd0, 32'h0000_03E7, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        // From here on the stored robot position replaces the planned one.
        add_row(sctg_pkg::OP_UPDATE, C_MIN, C_MAX, 32'hFFFF_FFFF, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, 24'sd5, 24'sd5, 32'hAAAA_5555, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_UPDATE, 24'sd0, 24'sd0, 32'd0, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, C_MAX, C_MIN, 32'hFFFF_0000, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_UPDATE, C_MAX, C_MAX, 32'h5555_AAAA, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, C_MIN, C_MIN, 32'hFFFF_0010, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);
        add_row(sctg_pkg::OP_REQUEST, -24'sd1, -24'sd1, 32'h0000_8000, 1'b0,
                sctg_pkg::VERDICT_OK, 1'b0);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].t, directed_rows[i].typed,
                      directed_rows[i].verdict, directed_rows[i].used);

        clock_ms = trig_last_time;
        for (p = 0; p < 9; p++) begin
            case (p)
                0:       begin ms = 16'd500;        cd = 16'd1000;       end
                1:       begin ms = 16'd0;          cd = 16'd0;          end
                2:       begin ms = 16'd65535;      cd = 16'd65535;      end
                3:       begin ms = 16'd1;          cd = 16'd1;          end
                4:       begin ms = 16'd65535;      cd = 16'd0;          end
                5:       begin ms = 16'd0;          cd = 16'd65535;      end
                6:       begin ms = 16'($urandom);  cd = 16'($urandom);  end
                7:       begin ms = 16'd200;        cd = 16'd50;         end
                default: begin ms = 16'd2000;       cd = 16'd300;        end
            endcase
            drain();
            write_reg(sctg_pkg::REG_MIN_STEP, ms);
            write_reg(sctg_pkg::REG_COOLDOWN, cd);
            // One phase runs with neither side idling.
            steady = (p == 3);
            run_phase(180);
        end

        drain();
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
